### src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while in reset.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/ucfp_pkg.sv
// Types and constants for the UART command frame parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ucfp_pkg;

  localparam logic [7:0] CH_START   = 8'h53;  // 'S'
  localparam logic [7:0] CH_DUTY    = 8'h44;  // 'D'
  localparam logic [7:0] CH_FREQ    = 8'h46;  // 'F'
  localparam logic [7:0] CH_END     = 8'h45;  // 'E'
  localparam logic [7:0] CH_ONE     = 8'd49;  // '1'
  localparam logic [7:0] FREQ_SPLIT = 8'd16;
  localparam logic [7:0] DUTY_SPLIT = 8'd5;
  localparam logic [7:0] DUTY_BASE  = 8'd3;
  localparam logic [7:0] FREQ_BASE_SINGLE = 8'd6;
  localparam logic [7:0] FREQ_BASE_DUAL   = 8'd8;
  localparam int         DUTY_DEPTH = 2;
  localparam int         FREQ_DEPTH = 8;
  localparam logic [7:0] POS_MAX    = 8'd255;

  localparam int OUT_BITS  = 178;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  typedef struct packed {
    logic                        frame;
    logic                        mode_sec;
    logic                        duty_sec;
    logic                        freq_sec;
    logic                        dual;
    logic [7:0]                  position;
    logic [7:0]                  mode_store;
    logic [DUTY_DEPTH-1:0][7:0]  duty_one;
    logic [DUTY_DEPTH-1:0][7:0]  duty_two;
    logic [FREQ_DEPTH-1:0][7:0]  freq_one;
    logic [FREQ_DEPTH-1:0][7:0]  freq_two;
  } ucfp_state_t;

endpackage

`default_nettype wire

### src/ucfp_step.sv
// Next-state logic for one received byte of the command frame parser.
// Depends on ucfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucfp_step (
  input  wire logic [7:0]          rx_byte,
  input  wire ucfp_pkg::ucfp_state_t cur,
  output ucfp_pkg::ucfp_state_t    nxt
);

  logic [7:0] pos_inc;

  assign pos_inc = (cur.position == ucfp_pkg::POS_MAX) ? cur.position : cur.position + 8'd1;

  always_comb begin
    nxt = cur;
    case (rx_byte)
      ucfp_pkg::CH_START: begin
        nxt.frame    = 1'b1;
        nxt.mode_sec = 1'b1;
        nxt.duty_sec = 1'b0;
        nxt.freq_sec = 1'b0;
        nxt.position = pos_inc;
      end
      ucfp_pkg::CH_DUTY: begin
        nxt.mode_sec = 1'b0;
        nxt.duty_sec = 1'b1;
        nxt.freq_sec = 1'b0;
        nxt.position = pos_inc;
      end
      ucfp_pkg::CH_FREQ: begin
        nxt.mode_sec = 1'b0;
        nxt.duty_sec = 1'b0;
        nxt.freq_sec = 1'b1;
        nxt.position = pos_inc;
      end
      ucfp_pkg::CH_END: begin
        nxt.frame    = 1'b0;
        nxt.mode_sec = 1'b0;
        nxt.duty_sec = 1'b0;
        nxt.freq_sec = 1'b0;
        nxt.dual     = 1'b0;
        nxt.position = 8'd0;
      end
      default: begin
        if (cur.frame) begin
          if (cur.mode_sec) begin
            nxt.mode_store = rx_byte;
            if (rx_byte != ucfp_pkg::CH_ONE) nxt.dual = 1'b1;
          end
          // slot = position - base; only in-range slots take the byte
          if (cur.duty_sec) begin
            if (!cur.dual || cur.position < ucfp_pkg::DUTY_SPLIT) begin
              for (int i = 0; i < ucfp_pkg::DUTY_DEPTH; i++) begin
                if (cur.position == ucfp_pkg::DUTY_BASE + 8'(i)) nxt.duty_one[i] = rx_byte;
              end
            end else begin
              for (int i = 0; i < ucfp_pkg::DUTY_DEPTH; i++) begin
                if (cur.position == ucfp_pkg::DUTY_SPLIT + 8'(i)) nxt.duty_two[i] = rx_byte;
              end
            end
          end
          if (cur.freq_sec) begin
            for (int i = 0; i < ucfp_pkg::FREQ_DEPTH; i++) begin
              if (!cur.dual) begin
                if (cur.position == ucfp_pkg::FREQ_BASE_SINGLE + 8'(i))
                  nxt.freq_one[i] = rx_byte;
              end else if (cur.position < ucfp_pkg::FREQ_SPLIT) begin
                if (cur.position == ucfp_pkg::FREQ_BASE_DUAL + 8'(i))
                  nxt.freq_one[i] = rx_byte;
              end else begin
                if (cur.position == ucfp_pkg::FREQ_SPLIT + 8'(i))
                  nxt.freq_two[i] = rx_byte;
              end
            end
          end
          nxt.position = pos_inc;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### src/uart_command_frame_parser.sv
// UART command frame parser: one received byte per request in, one status result out.
// The result appears on the output register in the cycle after the byte is taken.
// Throughput: one byte per cycle; the single output register stalls intake only when
// it is full and not being taken downstream.
// Reset (rst_n low, synchronous): frame state, position, mode and text buffers clear to zero,
// the output register empties.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uart_command_frame_parser (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] rx_byte
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [7:0] echo_byte, [8] frame_open, [9] dual_channel, [17:10] mode_char,
  // [33:18] duty_one_text, [49:34] duty_two_text, [113:50] freq_one_text,
  // [177:114] freq_two_text, [183:178] zero
  output logic [ucfp_pkg::OUT_BYTES*8-1:0]        out_tdata
);

  ucfp_pkg::ucfp_state_t state_r, state_nxt;
  logic                  out_valid_r;
  logic [7:0]            echo_r;
  logic                  in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ucfp_step u_step (
    .rx_byte (in_tdata),
    .cur     (state_r),
    .nxt     (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      echo_r <= in_tdata;
    end
  end

  // Stores live in state_r, so the result register holds the snapshot after the byte.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, state_r.freq_two, state_r.freq_one, state_r.duty_two,
                       state_r.duty_one, state_r.mode_store, state_r.dual, state_r.frame,
                       echo_r};

  `ASSERT_NEXT(a_end_closes, in_acc && in_tdata == ucfp_pkg::CH_END,
               !state_r.frame && state_r.position == 8'd0 && !state_r.dual,
               "end marker did not close the frame")
  `ASSERT_NEXT(a_start_opens, in_acc && in_tdata == ucfp_pkg::CH_START,
               state_r.frame && state_r.mode_sec, "start marker did not open the frame")
  `ASSERT_CLKD(a_dual_in_frame, !state_r.frame |-> !state_r.dual,
               "dual channel set outside a frame")
  `ASSERT_NEXT(a_echo, in_acc, out_tvalid && out_tdata[7:0] == $past(in_tdata),
               "echo byte does not match the accepted request")

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for uart_command_frame_parser: directed and random byte streams.
// Depends on ucfp_pkg and the parser RTL; a built-in status predictor checks every result.
`timescale 1ns / 1ps

module testbench;

  localparam int RW = ucfp_pkg::OUT_BYTES * 8;
  localparam int NFIELDS = 9;

  // Predicts the echo and status word for every byte taken, checks results in order.
  class frame_status_board;
    logic [RW-1:0] status_due[$];
    int mismatches;
    int results_seen;
    int bytes_taken;
    bit open_f, mode_f, duty_f, freq_f, dual_f;
    logic [7:0] pos;
    logic [7:0] mode_chr;
    logic [7:0] duty_one[ucfp_pkg::DUTY_DEPTH];
    logic [7:0] duty_two[ucfp_pkg::DUTY_DEPTH];
    logic [7:0] freq_one[ucfp_pkg::FREQ_DEPTH];
    logic [7:0] freq_two[ucfp_pkg::FREQ_DEPTH];

    function new();
      mismatches = 0;
      results_seen = 0;
      bytes_taken = 0;
      {open_f, mode_f, duty_f, freq_f, dual_f} = '0;
      pos = '0;
      mode_chr = '0;
      foreach (duty_one[i]) begin
        duty_one[i] = '0;
        duty_two[i] = '0;
      end
      foreach (freq_one[i]) begin
        freq_one[i] = '0;
        freq_two[i] = '0;
      end
    endfunction

    function void step_pos();
      if (pos != ucfp_pkg::POS_MAX) pos = pos + 8'd1;
    endfunction

    function void take_byte(logic [7:0] b);
      int slot;
      logic [RW-1:0] st;
      bytes_taken++;
      case (b)
        ucfp_pkg::CH_START: begin
          open_f = 1'b1;
          {mode_f, duty_f, freq_f} = 3'b100;
          step_pos();
        end
        ucfp_pkg::CH_DUTY: begin
          {mode_f, duty_f, freq_f} = 3'b010;
          step_pos();
        end
        ucfp_pkg::CH_FREQ: begin
          {mode_f, duty_f, freq_f} = 3'b001;
          step_pos();
        end
        ucfp_pkg::CH_END: begin
          {open_f, mode_f, duty_f, freq_f, dual_f} = '0;
          pos = '0;
        end
        default: begin
          if (open_f) begin
            if (mode_f) begin
              mode_chr = b;
              if (b != ucfp_pkg::CH_ONE) dual_f = 1'b1;
            end
            // dual use splits the sections between the two channels by position
            if (duty_f) begin
              if (!dual_f || pos < ucfp_pkg::DUTY_SPLIT) begin
                slot = int'(pos) - int'(ucfp_pkg::DUTY_BASE);
                if (slot >= 0 && slot < ucfp_pkg::DUTY_DEPTH) duty_one[slot] = b;
              end else begin
                slot = int'(pos) - int'(ucfp_pkg::DUTY_SPLIT);
                if (slot >= 0 && slot < ucfp_pkg::DUTY_DEPTH) duty_two[slot] = b;
              end
            end
            if (freq_f) begin
              if (!dual_f) begin
                slot = int'(pos) - int'(ucfp_pkg::FREQ_BASE_SINGLE);
                if (slot >= 0 && slot < ucfp_pkg::FREQ_DEPTH) freq_one[slot] = b;
              end else if (pos < ucfp_pkg::FREQ_SPLIT) begin
                slot = int'(pos) - int'(ucfp_pkg::FREQ_BASE_DUAL);
                if (slot >= 0 && slot < ucfp_pkg::FREQ_DEPTH) freq_one[slot] = b;
              end else begin
                slot = int'(pos) - int'(ucfp_pkg::FREQ_SPLIT);
                if (slot >= 0 && slot < ucfp_pkg::FREQ_DEPTH) freq_two[slot] = b;
              end
            end
            step_pos();
          end
        end
      endcase
      st = '0;
      st[7:0] = b;
      st[8] = open_f;
      st[9] = dual_f;
      st[17:10] = mode_chr;
      for (int i = 0; i < ucfp_pkg::DUTY_DEPTH; i++) begin
        st[18 + 8*i +: 8] = duty_one[i];
        st[34 + 8*i +: 8] = duty_two[i];
      end
      for (int i = 0; i < ucfp_pkg::FREQ_DEPTH; i++) begin
        st[50 + 8*i +: 8] = freq_one[i];
        st[114 + 8*i +: 8] = freq_two[i];
      end
      status_due.push_back(st);
    endfunction

    function void match_status(logic [RW-1:0] got);
      string names[NFIELDS];
      int lsb[NFIELDS];
      int wid[NFIELDS];
      logic [RW-1:0] want, mask;
      names = '{"echo_byte", "frame_open", "dual_channel", "mode_char", "duty_one_text",
                "duty_two_text", "freq_one_text", "freq_two_text", "padding"};
      lsb = '{0, 8, 9, 10, 18, 34, 50, 114, 178};
      wid = '{8, 1, 1, 8, 16, 16, 64, 64, RW - 178};
      results_seen++;
      if (status_due.size() == 0) begin
        $display("%0t unexpected result, got %h", $time, got);
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      for (int f = 0; f < NFIELDS; f++) begin
        mask = (RW'(1) << wid[f]) - RW'(1);
        if (((want >> lsb[f]) & mask) !== ((got >> lsb[f]) & mask)) begin
          $display("%0t %s mismatch: expected %h, got %h", $time, names[f],
                   (want >> lsb[f]) & mask, (got >> lsb[f]) & mask);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [7:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [RW-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  frame_status_board board;

  uart_command_frame_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(1, 100) > recv_idle_pct);
  end

  // requests in are noted before results are checked, both on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.take_byte(in_tdata);
      if (out_tvalid && out_tready) board.match_status(out_tdata);
    end
  end

  initial begin
    #10ms;
    $display("[uart_command_frame_parser] ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic bit is_marker(logic [7:0] c);
    return c == ucfp_pkg::CH_START || c == ucfp_pkg::CH_DUTY ||
           c == ucfp_pkg::CH_FREQ || c == ucfp_pkg::CH_END;
  endfunction

  // random text character that cannot be taken for a marker
  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_marker(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_frame(input bit dual_use, input int duty_n, input int freq_n,
                            input bit freq_first, input bit with_mode, input bit close_it);
    logic [7:0] m;
    send_byte(ucfp_pkg::CH_START);
    if (with_mode) begin
      m = ucfp_pkg::CH_ONE;
      if (dual_use) while (m == ucfp_pkg::CH_ONE) m = pick_text();
      send_byte(m);
    end
    if (freq_first) begin
      send_byte(ucfp_pkg::CH_FREQ);
      repeat (freq_n) send_byte(pick_text());
      send_byte(ucfp_pkg::CH_DUTY);
      repeat (duty_n) send_byte(pick_text());
    end else begin
      send_byte(ucfp_pkg::CH_DUTY);
      repeat (duty_n) send_byte(pick_text());
      send_byte(ucfp_pkg::CH_FREQ);
      repeat (freq_n) send_byte(pick_text());
    end
    if (close_it) send_byte(ucfp_pkg::CH_END);
  endtask

  task automatic random_traffic(input int count);
    int stop_at, r, dn, fn;
    bit dual_use;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      dual_use = $urandom_range(0, 1);
      dn = dual_use ? 2 * ucfp_pkg::DUTY_DEPTH : ucfp_pkg::DUTY_DEPTH;
      fn = dual_use ? 2 * ucfp_pkg::FREQ_DEPTH : ucfp_pkg::FREQ_DEPTH;
      if (r < 50) begin
        send_frame(dual_use, dn, fn, 1'b0, 1'b1, 1'b1);
      end else if (r < 75) begin
        // odd lengths, swapped sections, missing mode byte or missing close
        send_frame(dual_use, $urandom_range(0, dn + 3), $urandom_range(0, fn + 3),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 5) != 0,
                   $urandom_range(0, 5) != 0);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0: send_byte(ucfp_pkg::CH_START);
          1: send_byte(ucfp_pkg::CH_DUTY);
          2: send_byte(ucfp_pkg::CH_FREQ);
          default: send_byte(ucfp_pkg::CH_END);
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // closed-frame data and markers, a single-channel frame with edge values,
    // a slot past the buffer, a reopen and a zero mode byte
    directed = {8'h00, 8'hFF, ucfp_pkg::CH_DUTY, ucfp_pkg::CH_FREQ, 8'h37, ucfp_pkg::CH_END,
                ucfp_pkg::CH_START, ucfp_pkg::CH_ONE, ucfp_pkg::CH_DUTY, 8'h00, 8'hFF,
                ucfp_pkg::CH_FREQ,
                8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                8'hAA, ucfp_pkg::CH_START, 8'h00, ucfp_pkg::CH_END};
    foreach (directed[i]) send_byte(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 6;  recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 0) begin
        // long dual frame: runs the position into saturation
        send_byte(ucfp_pkg::CH_START);
        send_byte(8'h32);
        send_byte(ucfp_pkg::CH_FREQ);
        repeat (260) send_byte(pick_text());
        send_byte(ucfp_pkg::CH_END);
        hold_until_drained();
      end
      random_traffic(500);
    end

    hold_until_drained();
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes over three handshake pressure phases incl. position saturation;",
             bytes_sent);
    $display("checked %0d results, %0d field mismatches.", board.results_seen,
             board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[uart_command_frame_parser] OK");
    end else begin
      $display("[uart_command_frame_parser] ERROR");
    end
    $finish;
  end

endmodule
